FILE: rtl/core/max_tracking_stack_defines.svh
// Assertion macros used by the max_tracking_stack checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef MAX_TRACKING_STACK_DEFINES_SVH
`define MAX_TRACKING_STACK_DEFINES_SVH

// Checked property, off while reset is held.
`define MTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked property, also sampled while reset is held.
`define MTS_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/mts_pkg.sv
// Package for max_tracking_stack: sizes, field positions, codes and the
// controller/datapath interface types. No dependencies.
package mts_pkg;

  localparam int unsigned STACK_DEPTH   = 1024;
  localparam int unsigned PTR_W         = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W         = $clog2(STACK_DEPTH + 1);

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FUNC_W        = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned ENTRY_COUNT_W = 11;

  // input tdata layout
  localparam int unsigned IN_FUNC_LSB   = 0;
  localparam int unsigned IN_VALUE_LSB  = IN_FUNC_LSB + FUNC_W;
  localparam int unsigned IN_USED_W     = IN_VALUE_LSB + DATA_W;
  localparam int unsigned IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout
  localparam int unsigned OUT_POPPED_LSB = 0;
  localparam int unsigned OUT_TOP_LSB    = OUT_POPPED_LSB + DATA_W;
  localparam int unsigned OUT_MAX_LSB    = OUT_TOP_LSB + DATA_W;
  localparam int unsigned OUT_EMPTY_POS  = OUT_MAX_LSB + DATA_W;
  localparam int unsigned OUT_COUNT_LSB  = OUT_EMPTY_POS + 1;
  localparam int unsigned OUT_STATUS_LSB = OUT_COUNT_LSB + ENTRY_COUNT_W;
  localparam int unsigned OUT_USED_W     = OUT_STATUS_LSB + STATUS_W;
  localparam int unsigned OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_READ = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic exec;   // input transfer: apply the operation
    logic load;   // take the refilled tops from the stores
    logic emit;   // load the output register
  } mts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_load;  // offered item is a pop on a non-empty stack
    logic out_free;   // output register can take a result this cycle
  } mts_stat_t;

endpackage

FILE: rtl/core/max_tracking_stack.sv
// Top level of max_tracking_stack: a bounded signed stack that reports
// its running maximum. Depends on mts_pkg, mts_ctrl and mts_datapath.
//
//  channel   dir  width  contents
//  s_axis    in   40     operation: func, push_value
//  m_axis    out  112    result: popped, top, max, empty, count, status
//
// Steps: a push or a read goes from the input transfer straight to the emit
// step; a pop on a non-empty stack first passes a load step, which takes the
// registered read of the entry below the top from the value and maxima stores.
// The next input transfer can be taken in the cycle after the result is loaded.
// Reset clears the counts, the output valid and the sequencer; store contents are not
// cleared, only written entries are ever read.
// A stalled output holds its result; the sequencer waits in its emit step
// until the output register is free.
module max_tracking_stack (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [1:0] func, [33:2] push_value, [39:34] zero
  input  logic [mts_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // master side
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [31:0] popped_value, [63:32] top_value, [95:64] max_value,
  // [96] is_empty, [107:97] entry_count, [109:108] status, [111:110] zero
  output logic [mts_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import mts_pkg::*;

  mts_cmd_t  cmd;
  mts_stat_t stat;

  // sequencer: one operation at a time
  mts_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  // stores, cached tops and the output register
  mts_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .in_tdata_i      (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

FILE: rtl/core/mts_ctrl.sv
// Sequencer for max_tracking_stack: accept, optional refill, emit.
// Depends on mts_pkg.
module mts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  mts_pkg::mts_stat_t stat_i,
  output mts_pkg::mts_cmd_t  cmd_o
);
  import mts_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = stat_i.need_load ? ST_LOAD : ST_EMIT;
        end
      end
      ST_LOAD: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    cmd_o           = '0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.exec      = s_axis_tvalid_i;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = stat_i.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/mts_datapath.sv
// Datapath for max_tracking_stack: value and maxima stores, cached tops,
// counts and the output register. Depends on mts_pkg.
module mts_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mts_pkg::mts_cmd_t                  cmd_i,
  output mts_pkg::mts_stat_t                 stat_o,
  input  logic [mts_pkg::IN_TDATA_W-1:0]     in_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [mts_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);
  import mts_pkg::*;

  // stores: entry 0 is the bottom; the top entry is also cached in top_q/max_q
  logic [DATA_W-1:0] vmem [STACK_DEPTH];
  logic [DATA_W-1:0] mmem [STACK_DEPTH];

  logic [CNT_W-1:0]   vcnt_q, vcnt_d;
  logic [CNT_W-1:0]   mcnt_q, mcnt_d;
  logic signed [DATA_W-1:0] top_q, top_d;
  logic signed [DATA_W-1:0] max_q, max_d;
  logic [DATA_W-1:0]  popped_q, popped_d;
  status_e            status_q, status_d;
  logic               max_pop_q, max_pop_d;
  logic [DATA_W-1:0]  vrd_q, mrd_q;
  logic               out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  func_e                    func;
  logic signed [DATA_W-1:0] push_value;
  logic                     is_full, is_empty, max_take;
  logic                     vwe, mwe, rd_en;
  logic [PTR_W-1:0]         v_raddr, m_raddr;

  assign func       = func_e'(in_tdata_i[IN_FUNC_LSB +: FUNC_W]);
  assign push_value = in_tdata_i[IN_VALUE_LSB +: DATA_W];
  assign is_full    = (vcnt_q == CNT_W'(STACK_DEPTH));
  assign is_empty   = (vcnt_q == '0);
  assign max_take   = (mcnt_q == '0) || (max_q <= push_value);

  // entry just below the current top
  assign v_raddr = PTR_W'(vcnt_q - CNT_W'(2));
  assign m_raddr = PTR_W'(mcnt_q - CNT_W'(2));

  assign stat_o.need_load = (func == FUNC_POP) && !is_empty;
  assign stat_o.out_free  = !out_valid_q || m_axis_tready_i;

  always_comb begin
    vcnt_d    = vcnt_q;
    mcnt_d    = mcnt_q;
    top_d     = top_q;
    max_d     = max_q;
    popped_d  = popped_q;
    status_d  = status_q;
    max_pop_d = max_pop_q;
    vwe       = 1'b0;
    mwe       = 1'b0;
    rd_en     = 1'b0;

    if (cmd_i.exec) begin
      popped_d  = '0;
      status_d  = STATUS_OK;
      max_pop_d = 1'b0;
      case (func)
        FUNC_PUSH: begin
          if (is_full) begin
            status_d = STATUS_OVERFLOW;
          end else begin
            vwe    = 1'b1;
            top_d  = push_value;
            vcnt_d = vcnt_q + CNT_W'(1);
            // maxima count never exceeds the value count, so it has room
            if (max_take) begin
              mwe    = 1'b1;
              max_d  = push_value;
              mcnt_d = mcnt_q + CNT_W'(1);
            end
          end
        end
        FUNC_POP: begin
          if (is_empty) begin
            status_d = STATUS_UNDERFLOW;
          end else begin
            vcnt_d   = vcnt_q - CNT_W'(1);
            popped_d = top_q;
            rd_en    = 1'b1;
            if (max_q == top_q) begin
              mcnt_d    = mcnt_q - CNT_W'(1);
              max_pop_d = 1'b1;
            end
          end
        end
        default: begin
          // read, and the unused code: no change
        end
      endcase
    end

    if (cmd_i.load) begin
      if (!is_empty) begin
        top_d = vrd_q;
      end
      if (max_pop_q && (mcnt_q != '0)) begin
        max_d = mrd_q;
      end
    end
  end

  always_comb begin
    out_data_d = '0;
    out_data_d[OUT_POPPED_LSB +: DATA_W]       = popped_q;
    out_data_d[OUT_TOP_LSB +: DATA_W]          = is_empty ? '0 : top_q;
    out_data_d[OUT_MAX_LSB +: DATA_W]          = is_empty ? '0 : max_q;
    out_data_d[OUT_EMPTY_POS]                  = is_empty;
    out_data_d[OUT_COUNT_LSB +: ENTRY_COUNT_W] = ENTRY_COUNT_W'(vcnt_q);
    out_data_d[OUT_STATUS_LSB +: STATUS_W]     = status_q;
  end

  always_ff @(posedge clk_i) begin
    if (vwe) begin
      vmem[vcnt_q[PTR_W-1:0]] <= push_value;
    end
    if (rd_en) begin
      vrd_q <= vmem[v_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      mmem[mcnt_q[PTR_W-1:0]] <= push_value;
    end
    if (rd_en) begin
      mrd_q <= mmem[m_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    max_q     <= max_d;
    popped_q  <= popped_d;
    status_q  <= status_d;
    max_pop_q <= max_pop_d;
    if (cmd_i.emit) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q      <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      vcnt_q <= vcnt_d;
      mcnt_q <= mcnt_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

FILE: rtl/core/mts_checker.sv
// Port-level checks for max_tracking_stack, bound to the top level.
// Depends on mts_pkg and max_tracking_stack_defines.svh.
`include "max_tracking_stack_defines.svh"

module mts_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [mts_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [mts_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import mts_pkg::*;

  logic                     r_empty;
  logic [ENTRY_COUNT_W-1:0] r_count;
  logic [STATUS_W-1:0]      r_status;
  logic [DATA_W-1:0]        r_popped, r_top, r_max;

  assign r_empty  = m_axis_tdata_o[OUT_EMPTY_POS];
  assign r_count  = m_axis_tdata_o[OUT_COUNT_LSB +: ENTRY_COUNT_W];
  assign r_status = m_axis_tdata_o[OUT_STATUS_LSB +: STATUS_W];
  assign r_popped = m_axis_tdata_o[OUT_POPPED_LSB +: DATA_W];
  assign r_top    = m_axis_tdata_o[OUT_TOP_LSB +: DATA_W];
  assign r_max    = m_axis_tdata_o[OUT_MAX_LSB +: DATA_W];

  `MTS_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result dropped while stalled")
  `MTS_ASSERT(a_empty_count, m_axis_tvalid_o |-> (r_empty == (r_count == '0)), "empty flag disagrees with count")
  `MTS_ASSERT(a_empty_zero, m_axis_tvalid_o && r_empty |-> (r_top == '0) && (r_max == '0), "empty result carries a top or maximum")
  `MTS_ASSERT(a_underflow, m_axis_tvalid_o && (r_status == STATUS_UNDERFLOW) |-> r_empty && (r_popped == '0), "underflow on a non-empty stack")
  `MTS_ASSERT_RST(a_rst_idle, !rst_ni |=> !m_axis_tvalid_o, "result shown during reset")

endmodule

bind max_tracking_stack mts_checker u_mts_checker (.*);
